@@ rtl/bmp24pi_pkg.sv @@
// Shared types and constants for the 24-bit BMP palette index decoder.
package bmp24pi_pkg;

  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned HCOUNT_W = 6;

  // Header layout of a BMP file with a BITMAPINFOHEADER.
  localparam logic [HCOUNT_W-1:0] HDR_LAST_POS  = 6'd53;
  localparam logic [HCOUNT_W-1:0] OFFSET_POS_LO = 6'd10;
  localparam logic [HCOUNT_W-1:0] OFFSET_POS_HI = 6'd13;
  localparam logic [HCOUNT_W-1:0] WIDTH_POS_LO  = 6'd18;
  localparam logic [HCOUNT_W-1:0] WIDTH_POS_HI  = 6'd21;
  localparam logic [HCOUNT_W-1:0] HEIGHT_POS_LO = 6'd22;
  localparam logic [HCOUNT_W-1:0] HEIGHT_POS_HI = 6'd25;
  localparam logic [HCOUNT_W-1:0] BPP_POS_LO    = 6'd28;
  localparam logic [HCOUNT_W-1:0] BPP_POS_HI    = 6'd29;

  localparam logic [31:0] PIXEL_OFFSET   = 32'd54;
  localparam logic [15:0] BITS_PER_PIXEL = 16'd24;

  // Request function codes.
  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_BYTE    = 1'b1;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] index;
  } match_t;

endpackage

@@ rtl/bmp24_palette_index_decoder.sv @@
// Top level of the 24-bit BMP byte stream to palette index decoder.
//
//   channel | valid / stall          | payload
//   --------+------------------------+--------------------------------------------------
//   in      | in_valid_i / in_stall_o| func_i first_byte_i data_byte_i entry_index_i
//           |                        | entry_color_i
//   out     | out_valid_o/out_stall_i| result_kind_o pixel_address_o color_index_o
//           |                        | no_match_o last_pixel_o
//
// One request is taken per cycle while the result side does not stall. A request
// waits in the input register, and its result, if it has one, is loaded into the
// result register as the request leaves it. The rate is set by the single pass
// through the palette comparators and the parser counters. Reset clears the
// parser and the whole palette at once; there is no clearing pass. A stall on
// the result side holds both registers and pushes back on the request side in
// the same cycle.
module bmp24_palette_index_decoder #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned PALETTE_SIZE = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic                               first_byte_i,
  input  logic [7:0]                         data_byte_i,
  input  logic [bmp24pi_pkg::INDEX_W-1:0]    entry_index_i,
  input  logic [bmp24pi_pkg::COLOR_W-1:0]    entry_color_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               result_kind_o,
  output logic [bmp24pi_pkg::ADDR_W-1:0]     pixel_address_o,
  output logic [bmp24pi_pkg::INDEX_W-1:0]    color_index_o,
  output logic                               no_match_o,
  output logic                               last_pixel_o
);

  // Column and row counters hold values up to the largest legal dimension.
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = RW + CW;
  localparam int unsigned AW = bmp24pi_pkg::ADDR_W;

  // Parser phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Input register.
  logic                            s1_valid_q;
  logic                            s1_func_q;
  logic                            s1_first_q;
  logic [7:0]                      s1_data_q;
  logic [bmp24pi_pkg::INDEX_W-1:0] s1_index_q;
  logic [bmp24pi_pkg::COLOR_W-1:0] s1_color_q;

  logic advance;
  logic take_in;

  // Parser state.
  logic [1:0]                       phase_q, phase_d;
  logic [bmp24pi_pkg::HCOUNT_W-1:0] hcount_q, hcount_d;
  logic [31:0]                      offset_q, offset_d;
  logic [31:0]                      width_q, width_d;
  logic [31:0]                      height_q, height_d;
  logic [15:0]                      bpp_q, bpp_d;
  logic [1:0]                       comp_q, comp_d;
  logic [15:0]                      saved_bg_q, saved_bg_d;
  logic [CW-1:0]                    col_q, col_d;
  logic [RW-1:0]                    row_q, row_d;
  logic [1:0]                       pad_q, pad_d;
  logic [AW-1:0]                    row_base_q, row_base_d;

  // Start address of the top-down row that arrives first; tracked every cycle
  // so it is settled long before the last header byte.
  logic [PW-1:0]                    first_base_q;
  logic [PW-1:0]                    first_base_d;

  // Result register.
  logic                             out_valid_q;
  logic                             res_kind_q, res_kind_d;
  logic [AW-1:0]                    res_addr_q, res_addr_d;
  logic [bmp24pi_pkg::INDEX_W-1:0]  res_index_q, res_index_d;
  logic                             res_nomatch_q, res_nomatch_d;
  logic                             res_last_q, res_last_d;
  logic                             res_fire;

  logic                             header_bad;
  logic                             col_end;
  logic                             row_end;
  logic [bmp24pi_pkg::COLOR_W-1:0]  pixel_color;
  bmp24pi_pkg::match_t              match;

  // The pipeline moves whenever the result register can take a new result.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take_in) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_func_q  <= func_i;
      s1_first_q <= first_byte_i;
      s1_data_q  <= data_byte_i;
      s1_index_q <= entry_index_i;
      s1_color_q <= entry_color_i;
    end
  end

  // Red is the byte in hand, green and blue were saved from the two before.
  assign pixel_color = {saved_bg_q[7:0], saved_bg_q[15:8], s1_data_q};

  bmp24pi_palette #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (advance && (s1_func_q == bmp24pi_pkg::FUNC_PALETTE)),
    .wr_index_i (s1_index_q),
    .wr_color_i (s1_color_q),
    .color_i    (pixel_color),
    .match_o    (match)
  );

  // Header checks work on the full signed fields as they arrived.
  assign header_bad = (offset_d != bmp24pi_pkg::PIXEL_OFFSET)
                   || (bpp_d != bmp24pi_pkg::BITS_PER_PIXEL)
                   || height_d[31] || (height_d == 32'd0)
                   || (height_d > 32'(MAX_HEIGHT))
                   || width_d[31] || (width_d == 32'd0)
                   || (width_d > 32'(MAX_WIDTH));

  // Past the header check the dimensions fit the counter widths.
  assign col_end = (CW'({1'b0, col_q} + 1'b1) == width_q[CW-1:0]);
  assign row_end = (RW'({1'b0, row_q} + 1'b1) == height_q[RW-1:0]);

  assign first_base_d = PW'(height_q[RW-1:0] - 1'b1) * PW'(width_q[CW-1:0]);

  always_comb begin
    phase_d       = phase_q;
    hcount_d      = hcount_q;
    offset_d      = offset_q;
    width_d       = width_q;
    height_d      = height_q;
    bpp_d         = bpp_q;
    comp_d        = comp_q;
    saved_bg_d    = saved_bg_q;
    col_d         = col_q;
    row_d         = row_q;
    pad_d         = pad_q;
    row_base_d    = row_base_q;
    res_fire      = 1'b0;
    res_kind_d    = bmp24pi_pkg::KIND_PIXEL;
    res_addr_d    = '0;
    res_index_d   = '0;
    res_nomatch_d = 1'b0;
    res_last_d    = 1'b0;

    if (advance && (s1_func_q == bmp24pi_pkg::FUNC_BYTE)) begin
      // A first byte abandons whatever file was in progress.
      if (s1_first_q) begin
        phase_d    = PH_HEADER;
        hcount_d   = '0;
        offset_d   = '0;
        width_d    = '0;
        height_d   = '0;
        bpp_d      = '0;
        comp_d     = '0;
        saved_bg_d = '0;
        col_d      = '0;
        row_d      = '0;
        pad_d      = '0;
        row_base_d = '0;
      end

      case (phase_d)
        PH_HEADER: begin
          // Little-endian fields fill by shifting each byte in from the top.
          case (hcount_d) inside
            [bmp24pi_pkg::OFFSET_POS_LO:bmp24pi_pkg::OFFSET_POS_HI]:
              offset_d = {s1_data_q, offset_d[31:8]};
            [bmp24pi_pkg::WIDTH_POS_LO:bmp24pi_pkg::WIDTH_POS_HI]:
              width_d = {s1_data_q, width_d[31:8]};
            [bmp24pi_pkg::HEIGHT_POS_LO:bmp24pi_pkg::HEIGHT_POS_HI]:
              height_d = {s1_data_q, height_d[31:8]};
            [bmp24pi_pkg::BPP_POS_LO:bmp24pi_pkg::BPP_POS_HI]:
              bpp_d = {s1_data_q, bpp_d[15:8]};
            default: ;
          endcase

          if (hcount_d == bmp24pi_pkg::HDR_LAST_POS) begin
            if (header_bad) begin
              phase_d    = PH_DONE;
              res_fire   = 1'b1;
              res_kind_d = bmp24pi_pkg::KIND_ERROR;
            end else begin
              phase_d    = PH_PIXELS;
              row_base_d = AW'(first_base_q);
            end
          end
          hcount_d = hcount_d + 1'b1;
        end

        PH_PIXELS: begin
          if (pad_q != 2'd0) begin
            pad_d = pad_q - 1'b1;
          end else begin
            case (comp_q)
              2'd0: begin
                saved_bg_d[7:0] = s1_data_q;
                comp_d          = 2'd1;
              end
              2'd1: begin
                saved_bg_d[15:8] = s1_data_q;
                comp_d           = 2'd2;
              end
              default: begin
                comp_d        = 2'd0;
                res_fire      = 1'b1;
                res_addr_d    = row_base_q + AW'(col_q);
                res_index_d   = match.hit ? match.index : '0;
                res_nomatch_d = !match.hit;
                res_last_d    = row_end && col_end;
                if (row_end && col_end) begin
                  phase_d = PH_DONE;
                end else if (col_end) begin
                  col_d      = '0;
                  row_d      = row_q + 1'b1;
                  row_base_d = row_base_q - AW'(width_q[CW-1:0]);
                  // Rows of 3*width bytes pad up to a multiple of four.
                  pad_d      = width_q[1:0];
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            endcase
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      hcount_q     <= '0;
      offset_q     <= '0;
      width_q      <= '0;
      height_q     <= '0;
      bpp_q        <= '0;
      comp_q       <= '0;
      saved_bg_q   <= '0;
      col_q        <= '0;
      row_q        <= '0;
      pad_q        <= '0;
      row_base_q   <= '0;
      first_base_q <= '0;
    end else begin
      phase_q      <= phase_d;
      hcount_q     <= hcount_d;
      offset_q     <= offset_d;
      width_q      <= width_d;
      height_q     <= height_d;
      bpp_q        <= bpp_d;
      comp_q       <= comp_d;
      saved_bg_q   <= saved_bg_d;
      col_q        <= col_d;
      row_q        <= row_d;
      pad_q        <= pad_d;
      row_base_q   <= row_base_d;
      first_base_q <= first_base_d;
    end
  end

  // Result register: loads whenever it is free or being drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      res_kind_q    <= res_kind_d;
      res_addr_q    <= res_addr_d;
      res_index_q   <= res_index_d;
      res_nomatch_q <= res_nomatch_d;
      res_last_q    <= res_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = res_kind_q;
  assign pixel_address_o = res_addr_q;
  assign color_index_o   = res_index_q;
  assign no_match_o      = res_nomatch_q;
  assign last_pixel_o    = res_last_q;

endmodule

@@ rtl/bmp24pi_palette.sv @@
// Palette storage with a first-match search across all slots.
module bmp24pi_palette #(
  parameter int unsigned PALETTE_SIZE = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [bmp24pi_pkg::INDEX_W-1:0]      wr_index_i,
  input  logic [bmp24pi_pkg::COLOR_W-1:0]      wr_color_i,
  input  logic [bmp24pi_pkg::COLOR_W-1:0]      color_i,
  output bmp24pi_pkg::match_t                  match_o
);

  localparam int unsigned IW = $clog2(PALETTE_SIZE);

  logic [bmp24pi_pkg::COLOR_W-1:0] entry_q [PALETTE_SIZE];
  logic                            wr_ok;

  assign wr_ok = wr_en_i && ({28'd0, wr_index_i} < 32'(PALETTE_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        entry_q[i] <= '0;
      end
    end else if (wr_ok) begin
      entry_q[wr_index_i[IW-1:0]] <= wr_color_i;
    end
  end

  // Walk from the top slot down so the lowest matching slot wins.
  always_comb begin
    match_o = '0;
    for (int i = PALETTE_SIZE - 1; i >= 0; i--) begin
      if (entry_q[i] == color_i) begin
        match_o.hit   = 1'b1;
        match_o.index = bmp24pi_pkg::INDEX_W'(i);
      end
    end
  end

endmodule

@@ rtl/bmp24pi_checker.sv @@
// Port-level checks for the BMP palette index decoder, bound to the top level.
module bmp24pi_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            func_i,
  input logic                            first_byte_i,
  input logic [7:0]                      data_byte_i,
  input logic [bmp24pi_pkg::INDEX_W-1:0] entry_index_i,
  input logic [bmp24pi_pkg::COLOR_W-1:0] entry_color_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            result_kind_o,
  input logic [bmp24pi_pkg::ADDR_W-1:0]  pixel_address_o,
  input logic [bmp24pi_pkg::INDEX_W-1:0] color_index_o,
  input logic                            no_match_o,
  input logic                            last_pixel_o
);

  // A stalled result stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(pixel_address_o) && $stable(color_index_o)
      && $stable(no_match_o) && $stable(last_pixel_o))
    else $error("result changed while stalled");

  // An error result carries nothing but its kind.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == bmp24pi_pkg::KIND_ERROR) |->
      (pixel_address_o == '0) && (color_index_o == '0) && !no_match_o && !last_pixel_o)
    else $error("error result with nonzero fields");

  // A transparent pixel reports slot zero.
  a_nomatch_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_match_o |-> (color_index_o == '0))
    else $error("transparent pixel with a slot index");

  // A fresh result follows a taken request through the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching request");

endmodule

bind bmp24_palette_index_decoder bmp24pi_checker u_bmp24pi_checker (.*);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the 24-bit BMP byte stream to palette index decoder.
`timescale 1ns / 1ps

module tb;
  import bmp24pi_pkg::*;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned MAX_H        = 1024;
  localparam int unsigned PAL_SLOTS    = 16;
  localparam int unsigned HEADER_BYTES = 54;
  localparam int unsigned RANDOM_REQS  = 700;
  localparam int unsigned RANDOM_PIXELS = 48;

  // One request on the input channel, field by field as the ports carry it.
  typedef struct packed {
    logic               func;
    logic               first_flag;
    logic [7:0]         data;
    logic [INDEX_W-1:0] slot;
    logic [COLOR_W-1:0] color;
  } bmp_request_t;

  // One result on the output channel.
  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  address;
    logic [INDEX_W-1:0] index;
    logic               miss;
    logic               last;
  } pixel_result_t;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_HEADER,
    PARSE_PIXELS,
    PARSE_DONE
  } parse_phase_e;

  typedef enum logic [1:0] {
    ROW_STRAY,
    ROW_PALETTE,
    ROW_FILE
  } row_kind_e;

  // A row of the directed table. For a file, span is the number of pixel rows
  // actually sent after the header (zero when the header is meant to be
  // rejected); for stray bytes it is the number of bytes. A nonzero cut stops
  // the file after that many bytes so that the next file restarts the parser.
  typedef struct packed {
    row_kind_e           kind;
    logic [INDEX_W-1:0]  slot;
    logic [COLOR_W-1:0]  color;
    logic [31:0]         offset;
    logic [31:0]         width;
    logic [31:0]         height;
    logic [15:0]         bpp;
    logic [15:0]         span;
    logic [15:0]         cut;
    logic                mid_palette;
    logic                typed_error;
  } stimulus_row_t;

  // A rejected header always gives this one result, whatever the bytes were.
  localparam pixel_result_t HEADER_ERROR = '{KIND_ERROR, 20'd0, 4'd0, 1'b0, 1'b0};

  localparam int unsigned DIRECTED_N = 25;
  localparam stimulus_row_t DIRECTED [DIRECTED_N] = '{
    // Bytes with no file open right after reset are dropped.
    '{ROW_STRAY,   0, 0,            0,             0,            0,             0,  3, 0, 0, 0},
    // Palette is all zero here, so black pixels land on slot zero.
    '{ROW_FILE,    0, 0,            54,            2,            2,             24, 2, 0, 0, 0},
    // Palette writes carry a set first-byte flag, which must not start a file.
    '{ROW_PALETTE, 0, 24'hFFFFFF,   0,             0,            0,             0,  0, 0, 0, 0},
    '{ROW_PALETTE, 15, 24'h00FF00,  0,             0,            0,             0,  0, 0, 0, 0},
    '{ROW_PALETTE, 1, 24'hFFFFFF,   0,             0,            0,             0,  0, 0, 0, 0},
    '{ROW_FILE,    0, 0,            54,            3,            2,             24, 2, 0, 0, 0},
    // Trailing bytes after the last pixel are dropped.
    '{ROW_STRAY,   0, 0,            0,             0,            0,             0,  4, 0, 0, 0},
    // Every way a header can be rejected; the result is typed in.
    '{ROW_FILE,    0, 0,            55,            2,            2,             24, 0, 0, 0, 1},
    '{ROW_STRAY,   0, 0,            0,             0,            0,             0,  3, 0, 0, 0},
    '{ROW_FILE,    0, 0,            54,            2,            2,             32, 0, 0, 0, 1},
    '{ROW_FILE,    0, 0,            54,            2,            2,        16'h0118, 0, 0, 0, 1},
    '{ROW_FILE,    0, 0,            54,            2,            0,             24, 0, 0, 0, 1},
    '{ROW_FILE,    0, 0,            54,            2,            32'hFFFFFFFF,  24, 0, 0, 0, 1},
    '{ROW_FILE,    0, 0,            54,            2,            1025,          24, 0, 0, 0, 1},
    '{ROW_FILE,    0, 0,            54,            0,            2,             24, 0, 0, 0, 1},
    '{ROW_FILE,    0, 0,            54,            32'h80000000, 2,             24, 0, 0, 0, 1},
    '{ROW_FILE,    0, 0,            54,            1025,         2,             24, 0, 0, 0, 1},
    '{ROW_FILE,    0, 0,            32'h01000036,  2,            2,             24, 0, 0, 0, 1},
    // A file abandoned inside its header, then one abandoned inside its pixels.
    '{ROW_FILE,    0, 0,            54,            4,            2,             24, 2, 30, 0, 0},
    '{ROW_FILE,    0, 0,            54,            5,            3,             24, 3, 70, 0, 0},
    // A palette write halfway through the pixels.
    '{ROW_FILE,    0, 0,            54,            4,            3,             24, 3, 0, 1, 0},
    // Single pixel, widest image and tallest image.
    '{ROW_FILE,    0, 0,            54,            1,            1,             24, 1, 0, 0, 0},
    '{ROW_FILE,    0, 0,            54,            1024,         1,             24, 1, 0, 0, 0},
    '{ROW_FILE,    0, 0,            54,            1,            1024,          24, 1024, 0, 0, 0},
    '{ROW_STRAY,   0, 0,            0,             0,            0,             0,  2, 0, 0, 0}
  };

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                func_i        = FUNC_PALETTE;
  logic                first_byte_i  = 1'b0;
  logic [7:0]          data_byte_i   = '0;
  logic [INDEX_W-1:0]  entry_index_i = '0;
  logic [COLOR_W-1:0]  entry_color_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic                result_kind_o;
  logic [ADDR_W-1:0]   pixel_address_o;
  logic [INDEX_W-1:0]  color_index_o;
  logic                no_match_o;
  logic                last_pixel_o;

  bmp24_palette_index_decoder #(
    .MAX_WIDTH   (MAX_W),
    .MAX_HEIGHT  (MAX_H),
    .PALETTE_SIZE(PAL_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .first_byte_i   (first_byte_i),
    .data_byte_i    (data_byte_i),
    .entry_index_i  (entry_index_i),
    .entry_color_i  (entry_color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .pixel_address_o(pixel_address_o),
    .color_index_o  (color_index_o),
    .no_match_o     (no_match_o),
    .last_pixel_o   (last_pixel_o)
  );

  // Decoder state as the testbench tracks it, updated once per accepted request.
  logic [COLOR_W-1:0] palette_words [PAL_SLOTS];
  parse_phase_e       parse_phase;
  int unsigned        header_pos;
  logic [31:0]        offset_field;
  logic [31:0]        width_field;
  logic [31:0]        height_field;
  logic [15:0]        bpp_field;
  int unsigned        component;
  logic [7:0]         blue_byte;
  logic [7:0]         green_byte;
  int unsigned        column;
  int unsigned        row;
  int unsigned        pad_left;
  logic [ADDR_W-1:0]  row_base;

  pixel_result_t awaited_results [$];
  logic          typed_error_armed = 1'b0;

  int unsigned sender_idle_pct   = 33;
  int unsigned receiver_idle_pct = 50;
  int unsigned requests_counted  = 0;
  int unsigned results_predicted = 0;
  int unsigned mismatches        = 0;

  logic          took_valid = 1'b0;
  pixel_result_t took_result;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Queues the next expected result. While a directed row with a typed-in
  // result is running, that value stands in for the computed one.
  function automatic void record_result(input pixel_result_t res);
    if (typed_error_armed) begin
      awaited_results.push_back(HEADER_ERROR);
      typed_error_armed = 1'b0;
    end else begin
      awaited_results.push_back(res);
    end
    results_predicted++;
  endfunction

  // Computes what one accepted request does to the decoder and which result,
  // if any, it produces.
  function automatic void decode_request(input bmp_request_t r);
    logic [COLOR_W-1:0] color;
    logic               found;
    logic [INDEX_W-1:0] hit;
    logic               bad;
    pixel_result_t      res;
    if (r.func == FUNC_PALETTE) begin
      if (r.slot < PAL_SLOTS) palette_words[r.slot] = r.color;
      return;
    end
    // A first byte throws away whatever file was in progress.
    if (r.first_flag) begin
      parse_phase  = PARSE_HEADER;
      header_pos   = 0;
      offset_field = '0;
      width_field  = '0;
      height_field = '0;
      bpp_field    = '0;
      component    = 0;
      blue_byte    = '0;
      green_byte   = '0;
      column       = 0;
      row          = 0;
      pad_left     = 0;
      row_base     = '0;
    end
    case (parse_phase)
      PARSE_HEADER: begin
        if (header_pos >= OFFSET_POS_LO && header_pos <= OFFSET_POS_HI) begin
          offset_field[8*(header_pos-OFFSET_POS_LO) +: 8] = r.data;
        end else if (header_pos >= WIDTH_POS_LO && header_pos <= WIDTH_POS_HI) begin
          width_field[8*(header_pos-WIDTH_POS_LO) +: 8] = r.data;
        end else if (header_pos >= HEIGHT_POS_LO && header_pos <= HEIGHT_POS_HI) begin
          height_field[8*(header_pos-HEIGHT_POS_LO) +: 8] = r.data;
        end else if (header_pos >= BPP_POS_LO && header_pos <= BPP_POS_HI) begin
          bpp_field[8*(header_pos-BPP_POS_LO) +: 8] = r.data;
        end
        if (header_pos == HDR_LAST_POS) begin
          // Width and height are signed in the file, so a set top bit rejects.
          bad = offset_field != PIXEL_OFFSET || bpp_field != BITS_PER_PIXEL ||
                height_field[31] || height_field == 0 || height_field > MAX_H ||
                width_field[31] || width_field == 0 || width_field > MAX_W;
          if (bad) begin
            parse_phase = PARSE_DONE;
            res         = '0;
            res.kind    = KIND_ERROR;
            record_result(res);
          end else begin
            // Rows arrive bottom-up, so the first row is the last one in memory.
            parse_phase = PARSE_PIXELS;
            row_base    = ADDR_W'((height_field - 32'd1) * width_field);
          end
        end
        header_pos++;
      end
      PARSE_PIXELS: begin
        if (pad_left != 0) begin
          pad_left--;
        end else if (component == 0) begin
          blue_byte = r.data;
          component = 1;
        end else if (component == 1) begin
          green_byte = r.data;
          component  = 2;
        end else begin
          component = 0;
          color     = {blue_byte, green_byte, r.data};
          found     = 1'b0;
          hit       = '0;
          for (int i = 0; i < PAL_SLOTS; i++) begin
            if (!found && palette_words[i] == color) begin
              found = 1'b1;
              hit   = INDEX_W'(i);
            end
          end
          res.kind    = KIND_PIXEL;
          res.address = row_base + ADDR_W'(column);
          res.index   = hit;
          res.miss    = !found;
          res.last    = (row + 1 == height_field) && (column + 1 == width_field);
          record_result(res);
          if (res.last) begin
            parse_phase = PARSE_DONE;
          end else if (column + 1 == width_field) begin
            column   = 0;
            row++;
            row_base = row_base - ADDR_W'(width_field);
            pad_left = (4 - (width_field * 3) % 4) % 4;
          end else begin
            column++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Half the pixels reuse a palette color so that hits are common.
  function automatic logic [COLOR_W-1:0] pick_color();
    if ($urandom_range(1) == 1) return palette_words[$urandom_range(PAL_SLOTS-1)];
    return COLOR_W'($urandom);
  endfunction

  // The fields a request does not use still get random values.
  function automatic bmp_request_t byte_request(input logic first_flag, input logic [7:0] data);
    return '{FUNC_BYTE, first_flag, data, INDEX_W'($urandom), COLOR_W'($urandom)};
  endfunction

  function automatic bmp_request_t palette_request(input logic [INDEX_W-1:0] slot,
                                                   input logic [COLOR_W-1:0] color,
                                                   input logic first_flag);
    return '{FUNC_PALETTE, first_flag, 8'($urandom), slot, color};
  endfunction

  // Presents one request at a falling edge, after a random gap, and holds it
  // until a rising edge sees it taken.
  task automatic push_request(input bmp_request_t r, input bit counted);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    func_i        = r.func;
    first_byte_i  = r.first_flag;
    data_byte_i   = r.data;
    entry_index_i = r.slot;
    entry_color_i = r.color;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_request(r);
    if (counted) requests_counted++;
  endtask

  task automatic send_strays(input int unsigned count);
    for (int i = 0; i < count; i++) push_request(byte_request(1'b0, 8'($urandom)), 1'b0);
  endtask

  // Builds a whole file as a byte stream and sends it, or its first cut bytes.
  // Header bytes outside the four fields are random.
  task automatic send_file(input logic [31:0] offset, input logic [31:0] width,
                           input logic [31:0] height, input logic [15:0] bpp,
                           input int unsigned rows, input int unsigned cut,
                           input bit mid_palette, input bit typed_error);
    logic [7:0]         bytes_q [$];
    logic [COLOR_W-1:0] color;
    int unsigned        pad;
    int unsigned        stop;
    int unsigned        mid;
    for (int i = 0; i < HEADER_BYTES; i++) bytes_q.push_back(8'($urandom));
    for (int k = 0; k < 4; k++) begin
      bytes_q[OFFSET_POS_LO + k] = offset[8*k +: 8];
      bytes_q[WIDTH_POS_LO + k]  = width[8*k +: 8];
      bytes_q[HEIGHT_POS_LO + k] = height[8*k +: 8];
    end
    bytes_q[BPP_POS_LO] = bpp[7:0];
    bytes_q[BPP_POS_HI] = bpp[15:8];
    pad = (4 - (width * 3) % 4) % 4;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < width; c++) begin
        color = pick_color();
        bytes_q.push_back(color[23:16]);
        bytes_q.push_back(color[15:8]);
        bytes_q.push_back(color[7:0]);
      end
      for (int p = 0; p < pad; p++) bytes_q.push_back(8'($urandom));
    end
    stop = (cut != 0 && cut < bytes_q.size()) ? cut : bytes_q.size();
    mid  = HEADER_BYTES + (bytes_q.size() - HEADER_BYTES) / 2;
    typed_error_armed = typed_error;
    for (int i = 0; i < stop; i++) begin
      if (mid_palette && i == mid) begin
        push_request(palette_request(INDEX_W'($urandom), pick_color(), 1'b1), 1'b1);
      end
      push_request(byte_request(i == 0, bytes_q[i]), 1'b1);
    end
    typed_error_armed = 1'b0;
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
    end
  endtask

  // The receiver stalls at random; the rate follows the current phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Results are taken at the rising edge and compared at the falling edge after it,
  // so that an expectation queued at the same edge is always in place.
  always @(posedge clk_i) begin
    took_valid  <= rst_ni && out_valid_o && !out_stall_i;
    took_result <= '{result_kind_o, pixel_address_o, color_index_o, no_match_o,
                     last_pixel_o};
  end

  always @(negedge clk_i) begin
    pixel_result_t want;
    if (took_valid) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result expected none actual kind %0h address %0h index %0h",
                 $time, took_result.kind, took_result.address, took_result.index);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (want !== took_result) begin
          mismatches++;
          check_field("result_kind", want.kind, took_result.kind);
          check_field("pixel_address", want.address, took_result.address);
          check_field("color_index", want.index, took_result.index);
          check_field("no_match", want.miss, took_result.miss);
          check_field("last_pixel", want.last, took_result.last);
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned   random_start;
    int unsigned   results_start;
    int unsigned   progress;
    int unsigned   pick;
    logic [31:0]   width;
    logic [31:0]   height;
    logic [31:0]   offset;
    logic [15:0]   bpp;
    int unsigned   rows;
    int unsigned   drain;

    for (int i = 0; i < PAL_SLOTS; i++) palette_words[i] = '0;
    parse_phase  = PARSE_IDLE;
    header_pos   = 0;
    offset_field = '0;
    width_field  = '0;
    height_field = '0;
    bpp_field    = '0;
    component    = 0;
    blue_byte    = '0;
    green_byte   = '0;
    column       = 0;
    row          = 0;
    pad_left     = 0;
    row_base     = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: the table covers header rejection, restarts, padding,
    // palette edge cases and the largest images.
    for (int i = 0; i < DIRECTED_N; i++) begin
      case (DIRECTED[i].kind)
        ROW_STRAY: send_strays(DIRECTED[i].span);
        ROW_PALETTE: begin
          push_request(palette_request(DIRECTED[i].slot, DIRECTED[i].color, 1'b1), 1'b1);
        end
        default: begin
          send_file(DIRECTED[i].offset, DIRECTED[i].width, DIRECTED[i].height,
                    DIRECTED[i].bpp, DIRECTED[i].span, DIRECTED[i].cut,
                    DIRECTED[i].mid_palette, DIRECTED[i].typed_error);
        end
      endcase
    end

    // Random part: mostly small well-formed files with random pixels, mixed
    // with palette writes, stray bytes, bad headers and abandoned files.
    random_start  = requests_counted;
    results_start = results_predicted;
    while (requests_counted - random_start < RANDOM_REQS ||
           results_predicted - results_start < RANDOM_PIXELS) begin
      progress = requests_counted - random_start;
      if (progress < RANDOM_REQS / 3) begin
        sender_idle_pct   = 33;
        receiver_idle_pct = 50;
      end else if (progress < 2 * RANDOM_REQS / 3) begin
        sender_idle_pct   = 50;
        receiver_idle_pct = 33;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        // A quarter of the writes copy another slot so that first-match
        // priority gets exercised.
        push_request(palette_request(INDEX_W'($urandom),
                                     ($urandom_range(3) == 0) ?
                                       palette_words[$urandom_range(PAL_SLOTS-1)] :
                                       COLOR_W'($urandom),
                                     1'($urandom)), 1'b1);
      end else if (pick < 20) begin
        send_strays($urandom_range(1, 3));
      end else begin
        offset = PIXEL_OFFSET;
        bpp    = BITS_PER_PIXEL;
        width  = $urandom_range(1, 4);
        height = $urandom_range(1, 3);
        rows   = height;
        if ($urandom_range(4) == 0) begin
          rows = 0;
          case ($urandom_range(3))
            0: begin
              offset = $urandom;
              if (offset == PIXEL_OFFSET) offset = PIXEL_OFFSET + 1;
            end
            1: begin
              bpp = 16'($urandom);
              if (bpp == BITS_PER_PIXEL) bpp = BITS_PER_PIXEL + 8;
            end
            2: begin
              case ($urandom_range(2))
                0: height = 0;
                1: height = $urandom | 32'h8000_0000;
                default: height = $urandom_range(MAX_H + 1, 70000);
              endcase
            end
            default: begin
              case ($urandom_range(2))
                0: width = 0;
                1: width = $urandom | 32'h8000_0000;
                default: width = $urandom_range(MAX_W + 1, 70000);
              endcase
            end
          endcase
        end
        send_file(offset, width, height, bpp, rows,
                  ($urandom_range(6) == 0) ? $urandom_range(1, 90) : 0,
                  $urandom_range(4) == 0, 1'b0);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;

    // Wait for the last results, which trail their requests through the input and
    // result registers, plus whatever the receiver stalls.
    drain = 0;
    while (awaited_results.size() != 0 && drain < 2000) begin
      @(negedge clk_i);
      drain++;
    end
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results expected actual none", $time, awaited_results.size());
      mismatches++;
    end
    repeat (8) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
